// ===== rtl/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg
// Shared widths, codes, constants and types for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int DEC_W      = COORD_BITS + 4;
  localparam int CFG_DIM_W  = 13;
  localparam int OFFSET_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int ADDR_W     = 24;
  localparam int COLOUR_W   = 24;
  localparam int CMP_W      = (COORD_BITS + 2 > CFG_DIM_W + 2) ? COORD_BITS + 2 : CFG_DIM_W + 2;
  localparam int PROD_W     = COORD_BITS + CFG_DIM_W + 1;
  localparam int SUM_W      = (PROD_W > ADDR_W) ? PROD_W + 1 : ADDR_W + 1;
  localparam int MARGIN     = 100;

  localparam logic [CFG_DIM_W-1:0] ROW_LENGTH_RST   = CFG_DIM_W'(1024);
  localparam logic [CFG_DIM_W-1:0] BOUND_SIZE_RST   = CFG_DIM_W'(1024);
  localparam logic [OFFSET_W-1:0]  PIXEL_OFFSET_RST = OFFSET_W'(2000);

  localparam logic [COLOUR_W-1:0] COL_XMAJ = 24'hFF00FF;
  localparam logic [COLOUR_W-1:0] COL_YMAJ = 24'hFFFF00;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH   = 2'd0,
    CFG_BOUND_SIZE   = 2'd1,
    CFG_PIXEL_OFFSET = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] row_length;
    logic [CFG_DIM_W-1:0] bound_size;
    logic [OFFSET_W-1:0]  pixel_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOUR_W-1:0]          colour;
    logic                         we;
    logic                         last;
  } pixel_t;

endpackage

// ===== rtl/brl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// brl_cfg_regs
// Configuration registers: row length, window size and address offset.
// ----------------------------------------------------------------------------
module brl_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [brl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [brl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output brl_pkg::cfg_t                    cfg_o
);
  import brl_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROW_LENGTH:   cfg_d.row_length   = cfg_data_i[CFG_DIM_W-1:0];
        CFG_BOUND_SIZE:   cfg_d.bound_size   = cfg_data_i[CFG_DIM_W-1:0];
        CFG_PIXEL_OFFSET: cfg_d.pixel_offset = cfg_data_i[OFFSET_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_length   <= ROW_LENGTH_RST;
      cfg_q.bound_size   <= BOUND_SIZE_RST;
      cfg_q.pixel_offset <= PIXEL_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/brl_walker.sv =====
// ----------------------------------------------------------------------------
// brl_walker
// Input register, line setup and one Bresenham step per request.
// ----------------------------------------------------------------------------
module brl_walker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] x_a_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] y_a_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] x_b_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] y_b_i,
  input  logic [brl_pkg::CFG_DIM_W-1:0]       bound_size_i,
  output logic                                pix_valid_o,
  input  logic                                pix_ready_i,
  output brl_pkg::pixel_t                     pix_o
);
  import brl_pkg::*;

  function automatic logic in_window(input logic signed [CMP_W-1:0] x,
                                     input logic signed [CMP_W-1:0] y,
                                     input logic [CFG_DIM_W-1:0]    b);
    logic signed [CMP_W-1:0] bs;
    logic signed [CMP_W-1:0] half;
    logic signed [CMP_W-1:0] marg;
    bs   = $signed(CMP_W'(b));
    marg = CMP_W'(MARGIN);
    half = $signed(CMP_W'(b >> 1)) + marg;
    return (x + half > 0) && (y < bs) && (x < bs + marg);
  endfunction

  function automatic logic walk_ok(input logic                    ym,
                                   input logic signed [CMP_W-1:0] e,
                                   input logic signed [CMP_W-1:0] x,
                                   input logic signed [CMP_W-1:0] y,
                                   input logic [CFG_DIM_W-1:0]    b);
    if (ym) return (y <= e) && (y > 0);
    return (x <= e) && (y > 0) && in_window(x, y, b);
  endfunction

  // input register
  logic                         in_valid_q;
  kind_e                        in_kind_q;
  logic signed [COORD_BITS-1:0] in_xa_q, in_ya_q, in_xb_q, in_yb_q;

  // line state
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] end_major_q, end_major_d;
  logic [DELTA_W-1:0]           delta_major_q, delta_major_d;
  logic [DELTA_W-1:0]           delta_minor_q, delta_minor_d;
  logic signed [DEC_W-1:0]      decision_q, decision_d;
  logic                         minor_neg_q, minor_neg_d;
  logic                         y_major_q, y_major_d;
  logic                         active_q, active_d;

  logic                         advance;

  // load setup
  logic signed [DELTA_W-1:0]    xa_e, ya_e, xb_e, yb_e, dx, dy;
  logic [DELTA_W-1:0]           adx, ady;
  logic                         ld_ymaj, ld_swap, ld_neg, ld_active;
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey, ld_end;
  logic signed [DELTA_W-1:0]    sx_e, sy_e, ex_e, ey_e, ld_dmaj_s, ld_dmin_s;
  logic [DELTA_W-1:0]           ld_dmaj, ld_dmin;
  logic signed [DEC_W-1:0]      ld_dec;

  // step
  logic                         st_minor;
  logic signed [DELTA_W-1:0]    minor_inc, cx_e, cy_e, nx, ny;
  logic signed [DEC_W-1:0]      two_dmaj, two_dmin, nd;
  logic                         st_active, st_we;

  assign advance    = in_valid_q && ((in_kind_q == KIND_LOAD) || !active_q || pix_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_kind_q <= kind_e'(kind_i);
      in_xa_q   <= x_a_i;
      in_ya_q   <= y_a_i;
      in_xb_q   <= x_b_i;
      in_yb_q   <= y_b_i;
    end
  end

  // line setup from a load request
  always_comb begin
    xa_e    = DELTA_W'(in_xa_q);
    ya_e    = DELTA_W'(in_ya_q);
    xb_e    = DELTA_W'(in_xb_q);
    yb_e    = DELTA_W'(in_yb_q);
    dx      = xb_e - xa_e;
    dy      = yb_e - ya_e;
    adx     = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
    ady     = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
    ld_ymaj = !(ady < adx);
    ld_swap = ld_ymaj ? (in_ya_q > in_yb_q) : (in_xa_q > in_xb_q);
    sx      = ld_swap ? in_xb_q : in_xa_q;
    sy      = ld_swap ? in_yb_q : in_ya_q;
    ex      = ld_swap ? in_xa_q : in_xb_q;
    ey      = ld_swap ? in_ya_q : in_yb_q;
    sx_e    = DELTA_W'(sx);
    sy_e    = DELTA_W'(sy);
    ex_e    = DELTA_W'(ex);
    ey_e    = DELTA_W'(ey);
    ld_dmaj_s = ld_ymaj ? (ey_e - sy_e) : (ex_e - sx_e);
    ld_dmin_s = ld_ymaj ? (ex_e - sx_e) : (ey_e - sy_e);
    ld_end    = ld_ymaj ? ey : ex;
    ld_dmaj   = DELTA_W'(ld_dmaj_s);
    ld_neg    = ld_dmin_s[DELTA_W-1];
    ld_dmin   = ld_neg ? DELTA_W'(-ld_dmin_s) : DELTA_W'(ld_dmin_s);
    ld_dec    = $signed(DEC_W'({ld_dmin, 1'b0})) - $signed(DEC_W'(ld_dmaj));
    ld_active = walk_ok(ld_ymaj, CMP_W'(ld_end), CMP_W'(sx), CMP_W'(sy), bound_size_i);
  end

  // one step along the major axis
  always_comb begin
    st_minor  = decision_q > 0;
    minor_inc = minor_neg_q ? -DELTA_W'(1) : DELTA_W'(1);
    cx_e      = DELTA_W'(cur_x_q);
    cy_e      = DELTA_W'(cur_y_q);
    nx        = cx_e;
    ny        = cy_e;
    if (y_major_q) begin
      if (st_minor) nx = cx_e + minor_inc;
      ny = cy_e + DELTA_W'(1);
    end else begin
      if (st_minor) ny = cy_e + minor_inc;
      nx = cx_e + DELTA_W'(1);
    end
    two_dmaj  = $signed(DEC_W'({delta_major_q, 1'b0}));
    two_dmin  = $signed(DEC_W'({delta_minor_q, 1'b0}));
    nd        = st_minor ? (decision_q - two_dmaj + two_dmin) : (decision_q + two_dmin);
    st_active = walk_ok(y_major_q, CMP_W'(end_major_q), CMP_W'(nx), CMP_W'(ny),
                        bound_size_i);
    st_we     = y_major_q ? in_window(CMP_W'(cur_x_q), CMP_W'(cur_y_q), bound_size_i)
                          : 1'b1;
  end

  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    end_major_d   = end_major_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    decision_d    = decision_q;
    minor_neg_d   = minor_neg_q;
    y_major_d     = y_major_q;
    active_d      = active_q;
    if (advance) begin
      if (in_kind_q == KIND_LOAD) begin
        cur_x_d       = sx;
        cur_y_d       = sy;
        end_major_d   = ld_end;
        delta_major_d = ld_dmaj;
        delta_minor_d = ld_dmin;
        decision_d    = ld_dec;
        minor_neg_d   = ld_neg;
        y_major_d     = ld_ymaj;
        active_d      = ld_active;
      end else if (active_q) begin
        // advance, wrapping the coordinates to their width
        cur_x_d    = nx[COORD_BITS-1:0];
        cur_y_d    = ny[COORD_BITS-1:0];
        decision_d = nd;
        active_d   = st_active;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      end_major_q   <= '0;
      delta_major_q <= '0;
      delta_minor_q <= '0;
      decision_q    <= '0;
      minor_neg_q   <= 1'b0;
      y_major_q     <= 1'b0;
      active_q      <= 1'b0;
    end else begin
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      end_major_q   <= end_major_d;
      delta_major_q <= delta_major_d;
      delta_minor_q <= delta_minor_d;
      decision_q    <= decision_d;
      minor_neg_q   <= minor_neg_d;
      y_major_q     <= y_major_d;
      active_q      <= active_d;
    end
  end

  assign pix_valid_o = in_valid_q && (in_kind_q == KIND_STEP) && active_q;
  assign pix_o.x      = cur_x_q;
  assign pix_o.y      = cur_y_q;
  assign pix_o.colour = y_major_q ? COL_YMAJ : COL_XMAJ;
  assign pix_o.we     = st_we;
  assign pix_o.last   = !st_active;

  a_not_last_keeps_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o && pix_ready_i && !pix_o.last |=> active_q)
    else $error("line went idle after a pixel not flagged last");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o && pix_ready_i && pix_o.last |=> !active_q)
    else $error("line still active after its last pixel");

  a_stalled_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o && !pix_ready_i |=> pix_valid_o && $stable(cur_x_q) && $stable(cur_y_q))
    else $error("line state moved while its pixel was stalled");

endmodule

// ===== rtl/brl_pixel_out.sv =====
// ----------------------------------------------------------------------------
// brl_pixel_out
// Frame-buffer address computation and result register.
// ----------------------------------------------------------------------------
module brl_pixel_out (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  brl_pkg::cfg_t                         cfg_i,
  input  logic                                  pix_valid_i,
  output logic                                  pix_ready_o,
  input  brl_pkg::pixel_t                       pix_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [brl_pkg::COORD_BITS-1:0] pixel_x_o,
  output logic signed [brl_pkg::COORD_BITS-1:0] pixel_y_o,
  output logic [brl_pkg::ADDR_W-1:0]            pixel_address_o,
  output logic [brl_pkg::COLOUR_W-1:0]          pixel_colour_o,
  output logic                                  write_enable_o,
  output logic                                  last_o
);
  import brl_pkg::*;

  logic                     out_valid_q;
  pixel_t                   pix_q;
  logic [ADDR_W-1:0]        addr_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  // address wraps modulo 2^ADDR_W, negative sums included
  always_comb begin
    prod = $signed(pix_i.y) * $signed({1'b0, cfg_i.row_length});
    sum  = SUM_W'($signed(pix_i.x)) + SUM_W'(prod) + $signed(SUM_W'(cfg_i.pixel_offset));
  end

  assign pix_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      pix_q  <= pix_i;
      addr_q <= sum[ADDR_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = pix_q.x;
  assign pixel_y_o       = pix_q.y;
  assign pixel_address_o = addr_q;
  assign pixel_colour_o  = pix_q.colour;
  assign write_enable_o  = pix_q.we;
  assign last_o          = pix_q.last;

  a_xmaj_always_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (pix_q.colour != COL_YMAJ) |-> pix_q.we)
    else $error("x-major pixel emitted without write enable");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_o |=> out_valid_q)
    else $error("taken pixel did not reach the result register");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !pix_valid_i |=> !out_valid_q)
    else $error("result register still full after drain");

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// A step request passes through the input register, then the result register,
// before its pixel shows on the outputs.
// Throughput: one request and one pixel per cycle while the sink keeps ready high.
// Load requests and steps of an idle line produce no result.
// Reset: row length 1024, window size 1024, offset 2000; no line loaded.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer Bresenham line walker emitting one frame-buffer pixel per step.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] x_a_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] y_a_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] x_b_i,
  input  logic signed [brl_pkg::COORD_BITS-1:0] y_b_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [brl_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [brl_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [brl_pkg::COORD_BITS-1:0] pixel_x_o,
  output logic signed [brl_pkg::COORD_BITS-1:0] pixel_y_o,
  output logic [brl_pkg::ADDR_W-1:0]            pixel_address_o,
  output logic [brl_pkg::COLOUR_W-1:0]          pixel_colour_o,
  output logic                                  write_enable_o,
  output logic                                  last_o
);
  import brl_pkg::*;

  cfg_t   cfg;
  pixel_t pix;
  logic   pix_valid;
  logic   pix_ready;

  brl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  brl_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .x_a_i        (x_a_i),
    .y_a_i        (y_a_i),
    .x_b_i        (x_b_i),
    .y_b_i        (y_b_i),
    .bound_size_i (cfg.bound_size),
    .pix_valid_o  (pix_valid),
    .pix_ready_i  (pix_ready),
    .pix_o        (pix)
  );

  brl_pixel_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .pix_valid_i     (pix_valid),
    .pix_ready_o     (pix_ready),
    .pix_i           (pix),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .pixel_colour_o  (pixel_colour_o),
    .write_enable_o  (write_enable_o),
    .last_o          (last_o)
  );

endmodule
